// ===== src/dsr_pkg.sv =====
// Shared types and constants of the double-precision square root pipeline.
`default_nettype none
package dsr_pkg;

   localparam int MANT_W   = 53;  // significand with its hidden bit
   localparam int REM_W    = 54;  // divider partial remainder
   localparam int QUO_BITS = 55;  // quotient bits per division
   localparam int EXP_W    = 12;  // unbiased exponent, two's complement
   localparam int PROD_W   = 106; // significand product

   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
   localparam logic [52:0] ROOT2_MANT   = 53'h16_A09E_667F_3BCD;

   typedef struct packed {
      logic             special;
      logic [63:0]      spec_bits;
      logic             invalid;
      logic [EXP_W-1:0] exp;
   } side_type;

   typedef struct packed {
      logic [MANT_W-1:0] m;
      logic [MANT_W-1:0] y;
      side_type          side;
   } iter_type;

   typedef struct packed {
      logic [63:0] root;
      logic        invalid;
   } res_type;

endpackage
`default_nettype wire

// ===== src/dsr_unpack.sv =====
// Operand decode and two-stage normalisation of the significand.
`default_nettype none
module dsr_unpack
   import dsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [63:0] in_bits,
   output logic             out_valid,
   output iter_type         out_item
);

   logic        vld_a_ff;
   side_type    side_a_ff, side_a_in;
   logic [63:0] word_a_ff, word_a_in;
   logic [5:0]  shift_a_ff, shift_a_in;
   logic        sub_a_ff, sub_a_in;

   logic        vld_b_ff;
   iter_type    item_b_ff, item_b_in;

   always_comb begin
      logic [10:0] ebits;
      logic [51:0] frac;
      logic        nan, zero, sign;
      logic [63:0] w;
      logic [5:0]  s;
      ebits = in_bits[62:52];
      frac  = in_bits[51:0];
      nan   = (ebits == EXP_ALL_ONES) && (frac != 52'd0);
      zero  = (in_bits[62:0] == 63'd0);
      sign  = in_bits[63];
      side_a_in.special   = (ebits == EXP_ALL_ONES) || zero || sign;
      side_a_in.spec_bits = nan ? (in_bits | QUIET_BIT) : in_bits;
      side_a_in.invalid   = sign && !nan && !zero;
      side_a_in.exp       = '0;
      sub_a_in            = (ebits == 11'd0);
      // Special operands get a harmless normal significand.
      if (side_a_in.special || !sub_a_in) begin
         w = {1'b1, frac, 11'd0};
      end else begin
         w = {frac, 12'd0};
      end
      s = 6'd0;
      if (w[63:32] == 32'd0) begin
         w = {w[31:0], 32'd0};
         s = s + 6'd32;
      end
      if (w[63:48] == 16'd0) begin
         w = {w[47:0], 16'd0};
         s = s + 6'd16;
      end
      word_a_in  = w;
      shift_a_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_valid;
      end
      if (en) begin
         side_a_ff  <= side_a_in;
         word_a_ff  <= word_a_in;
         shift_a_ff <= shift_a_in;
         sub_a_ff   <= sub_a_in;
      end
   end

   always_comb begin
      logic [63:0] w;
      logic [5:0]  s;
      w = word_a_ff;
      s = shift_a_ff;
      if (w[63:56] == 8'd0) begin
         w = {w[55:0], 8'd0};
         s = s + 6'd8;
      end
      if (w[63:60] == 4'd0) begin
         w = {w[59:0], 4'd0};
         s = s + 6'd4;
      end
      if (w[63:62] == 2'd0) begin
         w = {w[61:0], 2'd0};
         s = s + 6'd2;
      end
      if (w[63] == 1'b0) begin
         w = {w[62:0], 1'b0};
         s = s + 6'd1;
      end
      item_b_in.m    = w[63:11];
      item_b_in.y    = w[63:11];
      item_b_in.side = side_a_ff;
      // A subnormal's exponent is -1023 less the shift; 3073 is -1023 in 12 bits.
      if (sub_a_ff) begin
         item_b_in.side.exp = 12'd3073 - {6'd0, s};
      end else begin
         item_b_in.side.exp = {1'b0, side_a_ff.spec_bits[62:52]} - 12'd1023;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
      if (en) begin
         item_b_ff <= item_b_in;
      end
   end

   assign out_valid = vld_b_ff;
   assign out_item  = item_b_ff;

endmodule
`default_nettype wire

// ===== src/dsr_newton_step.sv =====
// One Newton step: a bit-per-stage restoring divider followed by two rounding stages.
`default_nettype none
module dsr_newton_step
   import dsr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire iter_type in_item,
   output logic          out_valid,
   output iter_type      out_item
);

   logic                vld_ff  [QUO_BITS];
   iter_type            item_ff [QUO_BITS];
   logic [REM_W-1:0]    rem_ff  [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff  [QUO_BITS];

   genvar k;
   for (k = 0; k < QUO_BITS; k++) begin : g_div
      logic                vld_prev;
      iter_type            item_prev;
      logic [REM_W-1:0]    rem_prev;
      logic [QUO_BITS-1:0] quo_prev;
      logic                ge;
      logic [MANT_W-1:0]   rem_sub;
      logic [REM_W-1:0]    rem_in;
      logic [QUO_BITS-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign item_prev = in_item;
         assign rem_prev  = {1'b0, in_item.m};
         assign quo_prev  = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign item_prev = item_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
      end

      // The remainder stays below twice the divisor, so one subtraction settles a bit.
      always_comb begin
         ge      = (rem_prev >= {1'b0, item_prev.y});
         rem_sub = ge ? MANT_W'(rem_prev - {1'b0, item_prev.y}) : rem_prev[MANT_W-1:0];
         rem_in  = {rem_sub, 1'b0};
         quo_in  = {quo_prev[QUO_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            item_ff[k] <= item_prev;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   // Quotient rounded to binary64, held in units of 2^-53.
   logic                vld_q_ff;
   iter_type            item_q_ff;
   logic [QUO_BITS-1:0] qr_ff, qr_in;

   always_comb begin
      logic [QUO_BITS-1:0] q;
      logic [MANT_W-1:0]   base;
      logic                guard, sticky, up;
      logic [MANT_W:0]     qv;
      q = quo_ff[QUO_BITS-1];
      if (q[QUO_BITS-1]) begin
         base   = q[QUO_BITS-1:2];
         guard  = q[1];
         sticky = q[0] | (rem_ff[QUO_BITS-1] != '0);
      end else begin
         base   = q[QUO_BITS-2:1];
         guard  = q[0];
         sticky = (rem_ff[QUO_BITS-1] != '0);
      end
      up = guard & (sticky | base[0]);
      qv = {1'b0, base} + {{MANT_W{1'b0}}, up};
      if (q[QUO_BITS-1]) begin
         qr_in = {qv, 1'b0};
      end else begin
         qr_in = {1'b0, qv};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_q_ff <= 1'b0;
      end else if (en) begin
         vld_q_ff <= vld_ff[QUO_BITS-1];
      end
      if (en) begin
         item_q_ff <= item_ff[QUO_BITS-1];
         qr_ff     <= qr_in;
      end
   end

   // The sum lies in [2,4); rounding it and halving gives the next estimate.
   logic     vld_y_ff;
   iter_type item_y_ff, item_y_in;

   always_comb begin
      logic [QUO_BITS:0] sum;
      logic [MANT_W:0]   base, yn;
      logic              up;
      sum  = (QUO_BITS+1)'({item_q_ff.y, 1'b0}) + (QUO_BITS+1)'(qr_ff);
      base = sum[QUO_BITS:2];
      up   = sum[1] & (sum[0] | base[0]);
      yn   = base + {{MANT_W{1'b0}}, up};
      item_y_in   = item_q_ff;
      item_y_in.y = yn[MANT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_y_ff <= 1'b0;
      end else if (en) begin
         vld_y_ff <= vld_q_ff;
      end
      if (en) begin
         item_y_ff <= item_y_in;
      end
   end

   assign out_valid = vld_y_ff;
   assign out_item  = item_y_ff;

endmodule
`default_nettype wire

// ===== src/dsr_scale.sv =====
// Odd-exponent multiply by the square root of two, rounding and result packing.
`default_nettype none
module dsr_scale
   import dsr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire iter_type in_item,
   output logic          out_valid,
   output res_type       out_res
);

   localparam int LO_W = 27;
   localparam int HI_W = MANT_W - LO_W;

   logic                   vld_a_ff;
   logic [MANT_W-1:0]      y_a_ff;
   side_type               side_a_ff;
   logic [2*HI_W-1:0]      pp_hh_ff;
   logic [HI_W+LO_W-1:0]   pp_hl_ff, pp_lh_ff;
   logic [2*LO_W-1:0]      pp_ll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_valid;
      end
      if (en) begin
         y_a_ff    <= in_item.y;
         side_a_ff <= in_item.side;
         pp_hh_ff  <= in_item.y[MANT_W-1:LO_W] * ROOT2_MANT[MANT_W-1:LO_W];
         pp_hl_ff  <= in_item.y[MANT_W-1:LO_W] * ROOT2_MANT[LO_W-1:0];
         pp_lh_ff  <= in_item.y[LO_W-1:0] * ROOT2_MANT[MANT_W-1:LO_W];
         pp_ll_ff  <= in_item.y[LO_W-1:0] * ROOT2_MANT[LO_W-1:0];
      end
   end

   logic              vld_b_ff;
   logic [MANT_W-1:0] y_b_ff;
   side_type          side_b_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = (PROD_W'(pp_hh_ff) << (2*LO_W))
              + (PROD_W'(pp_hl_ff) << LO_W)
              + (PROD_W'(pp_lh_ff) << LO_W)
              + PROD_W'(pp_ll_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
      if (en) begin
         y_b_ff    <= y_a_ff;
         side_b_ff <= side_a_ff;
         prod_ff   <= prod_in;
      end
   end

   logic    vld_c_ff;
   res_type res_c_ff, res_c_in;

   always_comb begin
      logic [MANT_W-1:0] base;
      logic              guard, sticky, up, bump;
      logic [MANT_W:0]   mv;
      logic [51:0]       frac;
      logic [EXP_W-1:0]  half, bexp;
      if (prod_ff[PROD_W-1]) begin
         base   = prod_ff[PROD_W-1:PROD_W-MANT_W];
         guard  = prod_ff[PROD_W-MANT_W-1];
         sticky = (prod_ff[PROD_W-MANT_W-2:0] != '0);
      end else begin
         base   = prod_ff[PROD_W-2:PROD_W-MANT_W-1];
         guard  = prod_ff[PROD_W-MANT_W-2];
         sticky = (prod_ff[PROD_W-MANT_W-3:0] != '0);
      end
      up = guard & (sticky | base[0]);
      mv = {1'b0, base} + {{MANT_W{1'b0}}, up};
      if (side_b_ff.exp[0]) begin
         frac = mv[MANT_W] ? 52'd0 : mv[51:0];
         bump = prod_ff[PROD_W-1] | mv[MANT_W];
      end else begin
         frac = y_b_ff[51:0];
         bump = 1'b0;
      end
      // Half the exponent rounded down serves both parities.
      half = {side_b_ff.exp[EXP_W-1], side_b_ff.exp[EXP_W-1:1]};
      bexp = half + 12'd1023 + {11'd0, bump};
      if (side_b_ff.special) begin
         res_c_in.root = side_b_ff.spec_bits;
      end else begin
         res_c_in.root = {1'b0, bexp[10:0], frac};
      end
      res_c_in.invalid = side_b_ff.special & side_b_ff.invalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (en) begin
         vld_c_ff <= vld_b_ff;
      end
      if (en) begin
         res_c_ff <= res_c_in;
      end
   end

   assign out_valid = vld_c_ff;
   assign out_res   = res_c_ff;

endmodule
`default_nettype wire

// ===== src/double_square_root.sv =====
// Top level of the pipelined binary64 square root.
//
// Operands arrive on the req_ channel (valid/ready) as binary64 bit patterns;
// each item returns one result on the rsp_ channel: the root's bit pattern
// and an invalid flag that marks a negative non-zero, non-NaN operand, which comes back as is.
// Zeros come back unchanged, NaNs come back quietened, +inf gives +inf.
// The operand is normalised in two stages, then runs through NEWTON_STEPS
// Newton steps of 57 stages each (a 55-stage restoring divider, one bit per
// stage, and two rounding stages), three stages of scaling and an output
// register. One item is taken every cycle while the skid register is empty.
// While the receiver stalls, one more item moves into a skid register behind
// the output register; only when that holds an item does req_ready fall and
// the whole pipeline freeze in place.
// A synchronous reset empties every stage; the block takes items from the
// cycle after reset is released.
`default_nettype none
module double_square_root
   import dsr_pkg::*;
#(
   parameter int NEWTON_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_operand_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_root_bits,
   output logic             rsp_invalid_flag
);

   logic     en;
   logic     chain_vld  [NEWTON_STEPS+1];
   iter_type chain_item [NEWTON_STEPS+1];
   logic     tail_vld;
   res_type  tail_res;

   logic    out_vld_ff, out_vld_in;
   res_type out_res_ff, out_res_in;
   logic    skid_vld_ff, skid_vld_in;
   res_type skid_res_ff, skid_res_in;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   dsr_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid & req_ready),
      .in_bits   (req_operand_bits),
      .out_valid (chain_vld[0]),
      .out_item  (chain_item[0])
   );

   genvar n;
   for (n = 0; n < NEWTON_STEPS; n++) begin : g_step
      dsr_newton_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_vld[n]),
         .in_item   (chain_item[n]),
         .out_valid (chain_vld[n+1]),
         .out_item  (chain_item[n+1])
      );
   end

   dsr_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (chain_vld[NEWTON_STEPS]),
      .in_item   (chain_item[NEWTON_STEPS]),
      .out_valid (tail_vld),
      .out_res   (tail_res)
   );

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_res_in  = out_res_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      if (skid_vld_ff) begin
         if (rsp_ready) begin
            out_vld_in  = 1'b1;
            out_res_in  = skid_res_ff;
            skid_vld_in = 1'b0;
         end
      end else if (out_vld_ff && !rsp_ready) begin
         skid_vld_in = tail_vld;
         skid_res_in = tail_res;
      end else begin
         out_vld_in = tail_vld;
         out_res_in = tail_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_root_bits    = out_res_ff.root;
   assign rsp_invalid_flag = out_res_ff.invalid;

   // The skid register only ever holds an item behind a full output register.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds an item while the output is empty");

   // A finished item arriving at a stalled output must be caught by the skid register.
   a_stall_catches : assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ready && !skid_vld_ff && tail_vld) |=> skid_vld_ff)
      else $error("item lost at a stalled output");

   // An invalid result always has its sign bit set, as the negative operand comes back unchanged.
   a_invalid_negative : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid_flag) |-> rsp_root_bits[63])
      else $error("invalid flag raised on a non-negative result");

endmodule
`default_nettype wire
